FILE: sv/lpnd_pkg.sv
// ----------------------------------------------------------------------------
// lpnd_pkg
// Types and constants shared by the length-prefixed nal deframer modules
// ----------------------------------------------------------------------------
package lpnd_pkg;

   localparam logic       OP_BYTE = 1'b0;
   localparam logic       OP_TAG  = 1'b1;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_OVERSIZE = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;
   localparam logic [1:0] STATUS_EMPTY    = 2'd3;

   localparam logic [7:0]  TYPE_FIELD_MASK = 8'h7e;
   localparam logic [5:0]  EMPTY_TYPE      = 6'd63;
   localparam logic [5:0]  VCL_LOW_MAX     = 6'd9;
   localparam logic [5:0]  VCL_HIGH_MIN    = 6'd16;
   localparam logic [5:0]  VCL_HIGH_MAX    = 6'd21;
   localparam logic [2:0]  PREFIX_BYTES    = 3'd4;
   localparam logic [24:0] RESET_MAX_LEN   = 25'd1048576;
   localparam logic [24:0] TYPE_BYTE_POS   = 25'd5;

   typedef struct packed {
      logic        op;
      logic [7:0]  stream_byte;
      logic [31:0] frame_tag;
   } lpnd_req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic        unit_first;
      logic        unit_last;
      logic [5:0]  unit_type;
      logic [31:0] tag_out;
      logic        tag_valid;
      logic [1:0]  status;
   } lpnd_rsp_type;

   // classified item handed from the front to the back
   typedef struct packed {
      logic        is_push;
      logic [7:0]  stream_byte;
      logic [31:0] frame_tag;
   } lpnd_item_type;

   function automatic logic is_vcl(input logic [5:0] t);
      return (t <= VCL_LOW_MAX) || ((t >= VCL_HIGH_MIN) && (t <= VCL_HIGH_MAX));
   endfunction

endpackage

FILE: sv/lpnd_ram.sv
// ----------------------------------------------------------------------------
// lpnd_ram
// Simple dual-port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module lpnd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/lpnd_front.sv
// ----------------------------------------------------------------------------
// lpnd_front
// Input side: accepts items, classifies them and queues them for the back end
// ----------------------------------------------------------------------------
module lpnd_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  lpnd_pkg::lpnd_req_type  req_data,
   output logic                    item_valid,
   output lpnd_pkg::lpnd_item_type item,
   input  logic                    item_pop
);
   import lpnd_pkg::*;

   lpnd_item_type slot_ff [2];
   lpnd_item_type new_item;
   logic          wr_idx_ff, wr_idx_in;
   logic          rd_idx_ff, rd_idx_in;
   logic [1:0]    count_ff, count_in;
   logic          push;

   always_comb begin
      new_item.is_push     = (req_data.op == OP_TAG);
      new_item.stream_byte = req_data.stream_byte;
      new_item.frame_tag   = req_data.frame_tag;
   end

   assign req_stall  = (count_ff == 2'd2);
   assign push       = req_valid && !req_stall;
   assign item_valid = (count_ff != 2'd0);
   assign item       = slot_ff[rd_idx_ff];

   always_comb begin
      wr_idx_in = push ? !wr_idx_ff : wr_idx_ff;
      rd_idx_in = item_pop ? !rd_idx_ff : rd_idx_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, item_pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_idx_ff] <= new_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= 1'b0;
         rd_idx_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: sv/lpnd_back.sv
// ----------------------------------------------------------------------------
// lpnd_back
// Execution side: unit parser, frame tag queue and result register
// ----------------------------------------------------------------------------
module lpnd_back #(
   parameter int TAG_DEPTH = 16,
   parameter int TAG_BITS  = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    item_valid,
   input  lpnd_pkg::lpnd_item_type item,
   output logic                    item_pop,
   input  logic [24:0]             max_unit_length,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output lpnd_pkg::lpnd_rsp_type  rsp_data
);
   import lpnd_pkg::*;

   localparam int AW = $clog2(TAG_DEPTH);

   // unit parser state
   logic          in_unit_ff, in_unit_in;
   logic [2:0]    prefix_ff, prefix_in;
   logic [31:0]   len_ff, len_in;
   logic [32:0]   total_ff, total_in;
   logic [24:0]   bytes_ff, bytes_in;
   logic [5:0]    type_ff, type_in;

   // tag queue pointers, index plus wrap bit
   logic [AW-1:0] rd_idx_ff, rd_idx_in;
   logic          rd_wrap_ff, rd_wrap_in;
   logic [AW-1:0] wr_idx_ff, wr_idx_in;
   logic          wr_wrap_ff, wr_wrap_in;
   logic          fifo_empty, fifo_full;

   logic                ram_we;
   logic [TAG_BITS-1:0] ram_rd_data;
   logic [TAG_BITS-1:0] head;
   logic                byp_ff;
   logic [TAG_BITS-1:0] byp_data_ff;

   lpnd_rsp_type  rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          advance;

   logic          last;
   logic [5:0]    type_now;
   logic [31:0]   full_len;
   logic [32:0]   len_total;
   logic [24:0]   bytes_inc;

   assign fifo_empty = (rd_idx_ff == wr_idx_ff) && (rd_wrap_ff == wr_wrap_ff);
   assign fifo_full  = (rd_idx_ff == wr_idx_ff) && (rd_wrap_ff != wr_wrap_ff);

   assign advance  = !rsp_valid_ff || !rsp_stall;
   assign item_pop = item_valid && advance;

   // head is re-read every cycle; a write to the head slot is forwarded for one cycle
   assign head = byp_ff ? byp_data_ff : ram_rd_data;

   lpnd_ram #(
      .WIDTH (TAG_BITS),
      .DEPTH (TAG_DEPTH)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_idx_ff),
      .wr_data (TAG_BITS'(item.frame_tag)),
      .rd_addr (rd_idx_in),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      rsp_in     = '0;
      in_unit_in = in_unit_ff;
      prefix_in  = prefix_ff;
      len_in     = len_ff;
      total_in   = total_ff;
      bytes_in   = bytes_ff;
      type_in    = type_ff;
      rd_idx_in  = rd_idx_ff;
      rd_wrap_in = rd_wrap_ff;
      wr_idx_in  = wr_idx_ff;
      wr_wrap_in = wr_wrap_ff;
      ram_we     = 1'b0;
      last       = 1'b0;
      type_now   = type_ff;
      full_len   = {len_ff[23:0], item.stream_byte};
      len_total  = {1'b0, full_len} + 33'd4;
      bytes_inc  = bytes_ff + 25'd1;

      if (item_pop) begin
         if (item.is_push) begin
            if (fifo_full) begin
               rsp_in.status = STATUS_FULL;
            end else begin
               ram_we = 1'b1;
               if (wr_idx_ff == AW'(TAG_DEPTH - 1)) begin
                  wr_idx_in  = '0;
                  wr_wrap_in = !wr_wrap_ff;
               end else begin
                  wr_idx_in = wr_idx_ff + AW'(1);
               end
            end
         end else begin
            rsp_in.out_byte   = item.stream_byte;
            rsp_in.byte_valid = 1'b1;
            if (!in_unit_ff) begin
               in_unit_in        = 1'b1;
               prefix_in         = 3'd1;
               bytes_in          = 25'd1;
               len_in            = {24'd0, item.stream_byte};
               type_in           = EMPTY_TYPE;
               rsp_in.unit_first = 1'b1;
            end else if (prefix_ff < PREFIX_BYTES) begin
               prefix_in = prefix_ff + 3'd1;
               bytes_in  = bytes_inc;
               len_in    = full_len;
               if (prefix_ff == PREFIX_BYTES - 3'd1) begin
                  total_in = len_total;
                  if (len_total > {8'd0, max_unit_length}) begin
                     rsp_in.byte_valid = 1'b0;
                     rsp_in.status     = STATUS_OVERSIZE;
                     in_unit_in        = 1'b0;
                     prefix_in         = 3'd0;
                     bytes_in          = 25'd0;
                     len_in            = 32'd0;
                     type_in           = EMPTY_TYPE;
                  end else if (full_len == 32'd0) begin
                     last = 1'b1;
                  end
               end
            end else begin
               bytes_in = bytes_inc;
               if (bytes_inc == TYPE_BYTE_POS) begin
                  type_now = 6'((item.stream_byte & TYPE_FIELD_MASK) >> 1);
                  type_in  = type_now;
               end
               if ({8'd0, bytes_inc} >= total_ff) begin
                  last = 1'b1;
               end
            end

            if (last) begin
               rsp_in.unit_last = 1'b1;
               rsp_in.unit_type = type_now;
               if ((type_now != EMPTY_TYPE) && is_vcl(type_now)) begin
                  if (fifo_empty) begin
                     rsp_in.status = STATUS_EMPTY;
                  end else begin
                     rsp_in.tag_out   = 32'(head);
                     rsp_in.tag_valid = 1'b1;
                     if (rd_idx_ff == AW'(TAG_DEPTH - 1)) begin
                        rd_idx_in  = '0;
                        rd_wrap_in = !rd_wrap_ff;
                     end else begin
                        rd_idx_in = rd_idx_ff + AW'(1);
                     end
                  end
               end
               in_unit_in = 1'b0;
               prefix_in  = 3'd0;
               bytes_in   = 25'd0;
               len_in     = 32'd0;
               type_in    = EMPTY_TYPE;
            end
         end
      end

      if (item_pop) begin
         rsp_valid_in = 1'b1;
      end else if (advance) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop) begin
         rsp_ff <= rsp_in;
      end
      byp_data_ff <= TAG_BITS'(item.frame_tag);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_unit_ff   <= 1'b0;
         prefix_ff    <= 3'd0;
         len_ff       <= 32'd0;
         total_ff     <= 33'd0;
         bytes_ff     <= 25'd0;
         type_ff      <= EMPTY_TYPE;
         rd_idx_ff    <= '0;
         rd_wrap_ff   <= 1'b0;
         wr_idx_ff    <= '0;
         wr_wrap_ff   <= 1'b0;
         byp_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_unit_ff   <= in_unit_in;
         prefix_ff    <= prefix_in;
         len_ff       <= len_in;
         total_ff     <= total_in;
         bytes_ff     <= bytes_in;
         type_ff      <= type_in;
         rd_idx_ff    <= rd_idx_in;
         rd_wrap_ff   <= rd_wrap_in;
         wr_idx_ff    <= wr_idx_in;
         wr_wrap_ff   <= wr_wrap_in;
         byp_ff       <= ram_we && (wr_idx_ff == rd_idx_in);
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: sv/length_prefixed_nal_deframer.sv
// ----------------------------------------------------------------------------
// length_prefixed_nal_deframer
// Deframes 4-byte length-prefixed nal units and pairs vcl units with frame tags
// ----------------------------------------------------------------------------
// Takes one item per clock, an encoder stream byte or a frame tag push, and
// gives exactly one result per item at that rate unless req_stall or rsp_stall
// holds the flow. Items pass through a two-entry queue at the input and then
// the result register, so the input and result sides stall independently; the
// result register frees up in the same cycle it is read. Frame tags sit in a
// TAG_DEPTH-entry ram whose head is read ahead each cycle, so a tag pushed in
// one cycle can be popped by the next. max_unit_length may only be written
// while no item is in flight; csr_ready is always high.
module length_prefixed_nal_deframer #(
   parameter int TAG_DEPTH = 16,
   parameter int TAG_BITS  = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  lpnd_pkg::lpnd_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output lpnd_pkg::lpnd_rsp_type rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [24:0]            csr_data
);
   import lpnd_pkg::*;

   logic          item_valid;
   lpnd_item_type item;
   logic          item_pop;
   logic [24:0]   max_len_ff, max_len_in;

   assign csr_ready  = 1'b1;
   assign max_len_in = (csr_valid && csr_ready) ? csr_data : max_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= RESET_MAX_LEN;
      end else begin
         max_len_ff <= max_len_in;
      end
   end

   lpnd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   lpnd_back #(
      .TAG_DEPTH (TAG_DEPTH),
      .TAG_BITS  (TAG_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .item_valid      (item_valid),
      .item            (item),
      .item_pop        (item_pop),
      .max_unit_length (max_len_ff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data)
   );

   // back end only takes from a queue that holds something
   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      item_pop |-> item_valid)
      else $error("back end popped an empty item queue");

   // an accepted transfer is waiting in the queue in the next cycle
   a_accept_queued: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> item_valid)
      else $error("accepted transfer missing from item queue");

   // a register write lands in the limit register
   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> max_len_ff == $past(csr_data))
      else $error("max unit length not updated by write");

endmodule
